// ----- rtl/skt_pkg.sv -----
// Shared types, constants and codes for the sorted key table.
package skt_pkg;

    // Table size and derived widths
    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int KEY_W  = 32;
    localparam int CALC_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream word widths, padded to whole bytes
    localparam int IN_BITS  = 2 + KEY_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = POS_W + STAT_W + POS_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    // Broadcast command to every cell
    typedef struct packed {
        logic ins_en;
        logic del_en;
        key_t key;
    } cell_cmd_t;

    // What a cell shows its neighbors and the top level
    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
        key_t key;
    } cell_tap_t;

endpackage

// ----- rtl/sorted_key_table.sv -----
// Sorted key table: a row of compare-and-shift cells behind a stream interface.
//
// Holds up to DEPTH signed 32-bit keys in nondecreasing order (duplicates
// allowed). Each input word carries an opcode and a key: insert places the key
// in order (status full when the table holds DEPTH keys), find returns the
// 1-based position of the first equal key (0 and status not-found on a miss),
// delete removes the first equal key. Every result word also carries the key
// count after the operation. One input word is taken per clock: every cell
// compares its key with the broadcast key in parallel and shifts toward or
// away from its neighbor in the same cycle, so the table is updated before the
// next word is seen. A result waits in an output register; a new word is taken
// whenever that register is empty or drained in the same cycle. The table is
// empty right after reset, with no clearing pass.
module sorted_key_table import skt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode[1:0], key[33:2], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // position[4:0], status[6:5], entry_count[11:7]
);

    op_t             op;
    key_t            in_key;
    logic            accept;
    cell_cmd_t       cmd;
    cell_tap_t       taps [DEPTH];
    cell_tap_t       edge_left;
    cell_tap_t       edge_right;
    logic [DEPTH:0]  lt_vec;
    logic [DEPTH-1:0] eq_vec;
    logic [DEPTH-1:0] valid_vec;
    logic            hit;
    logic            full;
    logic [CALC_W-1:0] rank;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    status_t          status_reg, status_next;
    logic [POS_W-1:0] cnt_out_reg;

    // Unpack the input word
    assign op     = op_t'(s_tdata[1:0]);
    assign in_key = s_tdata[2 +: KEY_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));

    // Broadcast command
    assign cmd.key    = in_key;
    assign cmd.ins_en = accept && (op == OP_INSERT) && !full;
    assign cmd.del_en = accept && (op == OP_DELETE) && hit;

    // Ends of the row
    assign edge_left  = '{valid: 1'b0, lt: 1'b1, eq: 1'b0, key: '0};
    assign edge_right = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, key: '0};

    // Row of cells
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            skt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .left    ((g == 0) ? edge_left : taps[(g == 0) ? 0 : g-1]),
                .right   ((g == DEPTH-1) ? edge_right : taps[(g == DEPTH-1) ? g : g+1]),
                .tap     (taps[g])
            );
            assign lt_vec[g]    = taps[g].lt;
            assign eq_vec[g]    = taps[g].eq;
            assign valid_vec[g] = taps[g].valid;
        end
    endgenerate
    assign lt_vec[DEPTH] = 1'b0;

    assign hit = |eq_vec;

    // Locate the boundary of the less-than prefix: that is the first-equal index
    always_comb begin
        rank = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lt_vec[i] && !lt_vec[i+1]) begin
                rank = rank | CALC_W'(i + 1);
            end
        end
    end

    // Result and count for the accepted word
    always_comb begin
        count_next  = count_reg;
        pos_next    = '0;
        status_next = ST_DONE;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (hit) begin
                    pos_next = POS_W'(rank + CALC_W'(1));
                end else begin
                    status_next = ST_MISSING;
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_MISSING;
                end
            end
            default: begin
                status_next = ST_MISSING;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg     <= pos_next;
            status_reg  <= status_next;
            cnt_out_reg <= POS_W'(CALC_W'(count_next));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({cnt_out_reg, status_reg, pos_reg});

    // Occupied cells always form a prefix of the row
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("occupied cells are not contiguous");

    // The count tracks the occupied cells
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("count disagrees with occupied cells");

    // The count never passes the table size
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond table size");

    // A full report leaves the table full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_INSERT && full) |=> (status_reg == ST_FULL) && full)
        else $error("full insert changed the table");

endmodule

// ----- rtl/skt_cell.sv -----
// One slot of the sorted table: holds a key, compares it, shifts left or right.
module skt_cell import skt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  cell_tap_t left,   // lower neighbor; the first cell sees lt high
    input  cell_tap_t right,  // upper neighbor; the last cell sees an empty slot
    output cell_tap_t tap
);

    logic valid_reg, valid_next;
    key_t key_reg, key_next;
    logic lt;

    // Compare against the broadcast key
    assign lt        = valid_reg && (key_reg < cmd.key);
    assign tap.valid = valid_reg;
    assign tap.lt    = lt;
    assign tap.eq    = valid_reg && (key_reg == cmd.key);
    assign tap.key   = key_reg;

    // Keep, take the new key, or shift from a neighbor
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (cmd.ins_en && !lt) begin
            if (left.lt) begin
                valid_next = 1'b1;
                key_next   = cmd.key;
            end else begin
                valid_next = left.valid;
                key_next   = left.key;
            end
        end else if (cmd.del_en && !lt) begin
            valid_next = right.valid;
            key_next   = right.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ----- sim/tb_sorted_key_table.sv -----
// Testbench for the sorted key table: random and directed traffic against a local table model.
`timescale 1ns / 1ps

module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PAD_W       = IN_W - KEY_W - 2;

    // Fields of one result word
    typedef struct packed {
        logic [POS_W-1:0] position;
        status_t          status;
        logic [POS_W-1:0] entry_count;
    } table_reply_t;

    // One pending result with the word that caused it
    typedef struct {
        op_t          op;
        key_t         key;
        table_reply_t reply;
    } pending_reply_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // opcode[1:0], key[33:2], zero pad
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // position[4:0], status[6:5], entry_count[11:7]

    // Local copy of the table
    key_t        model_keys[DEPTH];
    int unsigned model_count;

    pending_reply_t pending_replies[$];
    int             mismatches  = 0;
    int             cycle_count = 0;
    int             snd_idle_pct;
    int             rcv_idle_pct;

    table_reply_t   seen_reply;
    pending_reply_t oldest_reply;

    sorted_key_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Apply one operation to the local table and return the result it gives
    function automatic table_reply_t apply_table_op(input op_t op, input key_t k);
        table_reply_t r;
        int unsigned  at;
        int unsigned  hit;
        int unsigned  i;
        r.position = '0;
        r.status   = ST_DONE;
        hit = 0;
        while (hit < model_count && model_keys[hit] != k) hit++;
        case (op)
            OP_INSERT: begin
                if (model_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    at = 0;
                    while (at < model_count && model_keys[at] < k) at++;
                    for (i = model_count; i > at; i--) model_keys[i] = model_keys[i-1];
                    model_keys[at] = k;
                    model_count++;
                end
            end
            OP_FIND: begin
                if (hit < model_count) r.position = POS_W'(hit + 1);
                else r.status = ST_MISSING;
            end
            OP_DELETE: begin
                if (hit < model_count) begin
                    for (i = hit; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
                    model_count--;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            default: r.status = ST_MISSING;
        endcase
        r.entry_count = POS_W'(model_count);
        return r;
    endfunction

    // Send one word, idling first at random; leave tvalid high afterwards
    task automatic send_word(input op_t op, input key_t k);
        pending_reply_t p;
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, k, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p.op    = op;
        p.key   = k;
        p.reply = apply_table_op(op, k);
        pending_replies.push_back(p);
    endtask

    // Hold the input side until every pending result is out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Check each result word against the oldest pending one
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_reply.position    = m_tdata[4:0];
            seen_reply.status      = status_t'(m_tdata[6:5]);
            seen_reply.entry_count = m_tdata[11:7];
            if (pending_replies.size() == 0) begin
                $display("%0t ERROR unexpected result word: expected none, got %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                oldest_reply = pending_replies.pop_front();
                if (seen_reply.position !== oldest_reply.reply.position) begin
                    $display("%0t ERROR position (op %s key %0d): expected %0d, got %0d",
                             $time, oldest_reply.op.name(), oldest_reply.key,
                             oldest_reply.reply.position, seen_reply.position);
                    mismatches++;
                end
                if (seen_reply.status !== oldest_reply.reply.status) begin
                    $display("%0t ERROR status (op %s key %0d): expected %0d, got %0d",
                             $time, oldest_reply.op.name(), oldest_reply.key,
                             oldest_reply.reply.status, seen_reply.status);
                    mismatches++;
                end
                if (seen_reply.entry_count !== oldest_reply.reply.entry_count) begin
                    $display("%0t ERROR entry_count (op %s key %0d): expected %0d, got %0d",
                             $time, oldest_reply.op.name(), oldest_reply.key,
                             oldest_reply.reply.entry_count, seen_reply.entry_count);
                    mismatches++;
                end
            end
        end
    end

    // Pick a key: mostly ones already held or close to each other, some extremes
    function automatic key_t pick_key();
        int unsigned sel;
        key_t        k;
        sel = $urandom_range(0, 99);
        if (sel < 40 && model_count != 0) begin
            k = model_keys[$urandom_range(0, model_count - 1)];
        end else if (sel < 60) begin
            k = key_t'(int'($urandom_range(0, 8)) - 4);
        end else if (sel < 68) begin
            case ($urandom_range(0, 3))
                0:       k = 32'h8000_0000;
                1:       k = 32'h7FFF_FFFF;
                2:       k = '0;
                default: k = '1;
            endcase
        end else begin
            k = key_t'($urandom);
        end
        return k;
    endfunction

    // Lookups, deletes and the unused opcode on an empty table
    task automatic test_empty_table();
        send_word(OP_FIND,   key_t'(0));
        send_word(OP_DELETE, key_t'(32'h7FFF_FFFF));
        send_word(OP_NONE,   key_t'(32'h8000_0000));
    endtask

    // Extremes and duplicates go in order; first-equal lookup and delete
    task automatic test_insert_order_and_lookup();
        send_word(OP_INSERT, key_t'(32'h7FFF_FFFF));
        send_word(OP_INSERT, key_t'(32'h8000_0000));
        send_word(OP_INSERT, key_t'(0));
        send_word(OP_INSERT, key_t'(0));
        send_word(OP_FIND,   key_t'(0));
        send_word(OP_FIND,   key_t'(12345));
        send_word(OP_DELETE, key_t'(0));
        send_word(OP_DELETE, key_t'(-1));
        send_word(OP_NONE,   key_t'(32'h5A5A_A5A5));
    endtask

    // Fill to capacity, overflow once, find the last slot
    task automatic test_fill_to_capacity();
        int i;
        for (i = 0; i < 13; i++) send_word(OP_INSERT, key_t'(int'($urandom_range(0, 6)) - 3));
        send_word(OP_INSERT, key_t'(1));
        send_word(OP_FIND,   key_t'(32'h7FFF_FFFF));
        drain_results();
    endtask

    // Random bursts that lean toward filling or emptying the table
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_words);
        int   sent;
        int   burst;
        int   ins_pct;
        int   r;
        op_t  op;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_words) begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                default: ins_pct = 85;
            endcase
            for (burst = 0; burst < 16 && sent < n_words; burst++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    op = OP_NONE;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < ins_pct) op = OP_INSERT;
                    else if (r < ins_pct + (100 - ins_pct) / 2) op = OP_FIND;
                    else op = OP_DELETE;
                end
                send_word(op, pick_key());
                sent++;
            end
        end
        drain_results();
    endtask

    initial begin
        model_count  = 0;
        snd_idle_pct = 6;
        rcv_idle_pct = 57;
        foreach (model_keys[i]) model_keys[i] = '0;

        // Hold reset, then release it between clock edges
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_insert_order_and_lookup();
        test_fill_to_capacity();
        test_random_traffic(6, 57, 150);
        test_random_traffic(57, 6, 150);
        test_random_traffic(0, 0, 150);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
